[hdl/sweep_and_prune_broadphase_defines.svh]
// Shared assertion macros for the broadphase block.
`ifndef SWEEP_AND_PRUNE_BROADPHASE_DEFINES_SVH
`define SWEEP_AND_PRUNE_BROADPHASE_DEFINES_SVH

// Holds at every edge out of reset.
`define SAP_CHECK_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define SAP_CHECK_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

[hdl/sap_pkg.sv]
package sap_pkg;

  localparam int MAX_OBJECTS = 32;
  localparam int COORD_BITS  = 16;
  localparam int OBJ_W       = $clog2(MAX_OBJECTS);
  localparam int CNT_W       = OBJ_W + 1;
  localparam int OWN_W       = OBJ_W + 1;
  localparam int SLOTS       = 2 * MAX_OBJECTS + 2;
  localparam int POS_W       = $clog2(SLOTS);
  localparam int EP_DEPTH    = 3 * SLOTS;
  localparam int EP_AW       = $clog2(EP_DEPTH);
  localparam int EP_W        = COORD_BITS + OWN_W;
  localparam int POS_DEPTH   = 6 * MAX_OBJECTS;
  localparam int POS_AW      = $clog2(POS_DEPTH);
  localparam int PAIR_W      = 9;
  localparam int PAIR_MAX    = MAX_OBJECTS * (MAX_OBJECTS - 1) / 2;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  localparam coord_t COORD_TOP = {1'b0, {(COORD_BITS-1){1'b1}}};

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_UPDATE = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_FULL    = 2'd1;
  localparam logic [1:0] ERR_UNKNOWN = 2'd2;

  typedef struct packed {
    logic [1:0]         command;
    logic [4:0]         object;
    logic signed [15:0] min_x;
    logic signed [15:0] min_y;
    logic signed [15:0] min_z;
    logic signed [15:0] max_x;
    logic signed [15:0] max_y;
    logic signed [15:0] max_z;
  } in_item_t;

  typedef struct packed {
    logic [4:0] slot;
    logic       slot_valid;
    logic [8:0] pair_count;
    logic [1:0] error;
    logic       last;
  } out_item_t;

  function automatic logic [EP_AW-1:0] ep_addr(input logic [1:0] ax,
                                               input logic [POS_W-1:0] p);
    return EP_AW'(int'(ax) * SLOTS + int'(p));
  endfunction

  function automatic logic [POS_AW-1:0] pos_addr(input logic [OBJ_W-1:0] obj,
                                                 input logic [1:0] ax,
                                                 input logic m);
    return POS_AW'(int'(obj) * 6 + int'(ax) * 2 + int'(m));
  endfunction

endpackage

[hdl/sap_ram.sv]
module sap_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/sweep_and_prune_broadphase.sv]
// Incremental sweep-and-prune broadphase for up to 32 boxes.
// Input channel in_valid/in_stall/in_data carries one command beat: add a box,
// update a box, or query the partners of a box. Result channel
// out_valid/out_stall/out_data returns one beat for add, update, errors and
// unknown commands, and one beat per partner (ascending slot) for a query, or
// a single beat if it has none; the final beat of a command carries last.
// One command is in flight at a time; in_stall is low only when idle.
// Add and update each accept and dispatch the command, place every endpoint,
// insertion-sort it along its axis and end with the result beat. A swap between
// two boxes rereads their twelve positions, plus a read-modify-write of two
// flag rows when the pair changes state; a swap within one box skips both.
// A query scans its flag row bit by bit up to its highest partner.
// The result register lets a new command be accepted while the last result
// beat still waits; a stalled result holds and the sequencer waits on it.
// Reset clears the object count, the pair count and the valid bits of the
// position and flag memories; no clearing pass is needed.
`include "sweep_and_prune_broadphase_defines.svh"

module sweep_and_prune_broadphase (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sap_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output sap_pkg::out_item_t out_data
);
  import sap_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_ADD_EP, S_UPD_RDPOS, S_UPD_POS, S_UPD_OLD, S_STEP, S_CMP,
    S_SW2, S_RT_RD, S_RT_EVAL, S_RT_FA, S_RT_FB, S_NEXT_EP, S_Q_WAIT, S_Q_SCAN,
    S_EMIT
  } state_t;

  localparam int RT_N = 12;

  state_t                 state_r;
  in_item_t               req_r;
  logic [CNT_W-1:0]       count_r;
  logic [PAIR_W-1:0]      pair_r;
  logic [1:0]             ax_r;
  logic                   m_r;
  logic [POS_W-1:0]       pos_r;
  logic [POS_W-1:0]       top_r;
  logic                   dn_r;
  coord_t                 mv_val_r;
  logic [OWN_W-1:0]       mv_own_r;
  coord_t                 nb_val_r;
  logic [OWN_W-1:0]       nb_own_r;
  logic [OBJ_W-1:0]       ra_r;
  logic [OBJ_W-1:0]       rb_r;
  logic [3:0]             k_r;
  logic [POS_W-1:0]       pbuf_r [RT_N];
  logic                   hit_r;
  logic [OBJ_W-1:0]       j_r;
  logic [MAX_OBJECTS-1:0] row_r;
  logic [4:0]             em_slot_r;
  logic                   em_valid_r;
  logic [1:0]             em_err_r;
  logic                   out_valid_r;
  out_item_t              out_data_r;
  logic [POS_DEPTH-1:0]   pos_valid_r;
  logic [MAX_OBJECTS-1:0] flag_valid_r;
  logic [POS_AW-1:0]      pos_ra_r;
  logic [OBJ_W-1:0]       flag_ra_r;

  logic                   ep_we;
  logic [EP_AW-1:0]       ep_waddr;
  logic [EP_W-1:0]        ep_wdata;
  logic [EP_AW-1:0]       ep_raddr;
  logic [EP_W-1:0]        ep_rdata;
  logic                   pos_we;
  logic [POS_AW-1:0]      pos_waddr;
  logic [POS_W-1:0]       pos_wdata;
  logic [POS_AW-1:0]      pos_raddr;
  logic [POS_W-1:0]       pos_rdata;
  logic                   flag_we;
  logic [OBJ_W-1:0]       flag_waddr;
  logic [MAX_OBJECTS-1:0] flag_wdata;
  logic [OBJ_W-1:0]       flag_raddr;
  logic [MAX_OBJECTS-1:0] flag_rdata;

  coord_t                 newval_c;
  coord_t                 ep_val_c;
  logic [OWN_W-1:0]       ep_own_c;
  logic [OWN_W-1:0]       own_add_c;
  logic [POS_W-1:0]       pos_rd_c;
  logic [MAX_OBJECTS-1:0] flag_rd_c;
  logic [POS_W-1:0]       nb_c;
  logic [POS_W-1:0]       add_pos_c;
  logic [POS_W-1:0]       top_upd_c;
  logic                   bound_c;
  logic                   swap_c;
  logic                   upd_bad_c;
  logic [2:0]             sub_c;
  logic [OBJ_W-1:0]       rt_obj_c;
  logic                   hit_c;
  logic                   toggle_c;
  logic                   q_last_c;
  logic                   out_free;
  logic                   emit_c;

  sap_ram #(.WIDTH(EP_W), .DEPTH(EP_DEPTH)) u_ep_ram (
    .clk, .we(ep_we), .waddr(ep_waddr), .wdata(ep_wdata),
    .raddr(ep_raddr), .rdata(ep_rdata)
  );

  sap_ram #(.WIDTH(POS_W), .DEPTH(POS_DEPTH)) u_pos_ram (
    .clk, .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
    .raddr(pos_raddr), .rdata(pos_rdata)
  );

  sap_ram #(.WIDTH(MAX_OBJECTS), .DEPTH(MAX_OBJECTS)) u_flag_ram (
    .clk, .we(flag_we), .waddr(flag_waddr), .wdata(flag_wdata),
    .raddr(flag_raddr), .rdata(flag_rdata)
  );

  always_comb begin
    case ({ax_r, m_r})
      3'b000:  newval_c = req_r.min_x;
      3'b001:  newval_c = req_r.max_x;
      3'b010:  newval_c = req_r.min_y;
      3'b011:  newval_c = req_r.max_y;
      3'b100:  newval_c = req_r.min_z;
      3'b101:  newval_c = req_r.max_z;
      default: newval_c = req_r.min_x;
    endcase
  end

  assign ep_val_c  = coord_t'(ep_rdata[EP_W-1:OWN_W]);
  assign ep_own_c  = ep_rdata[OWN_W-1:0];
  assign own_add_c = {m_r, count_r[OBJ_W-1:0]};
  assign pos_rd_c  = pos_valid_r[pos_ra_r] ? pos_rdata : '0;
  assign flag_rd_c = flag_valid_r[flag_ra_r] ? flag_rdata : '0;
  assign nb_c      = dn_r ? pos_r - POS_W'(1) : pos_r + POS_W'(1);
  assign add_pos_c = POS_W'((int'(count_r) << 1) + 1 + int'(m_r));
  assign top_upd_c = POS_W'(int'(count_r) << 1);
  assign bound_c   = dn_r ? (pos_r > POS_W'(1)) : (pos_r < top_r);
  assign swap_c    = dn_r ? (mv_val_r < ep_val_c) : (mv_val_r > ep_val_c);
  assign upd_bad_c = (pos_rd_c == '0) || (pos_rd_c > top_upd_c);
  assign sub_c     = (k_r < 4'd6) ? 3'(k_r) : 3'(k_r - 4'd6);
  assign rt_obj_c  = (k_r < 4'd6) ? ra_r : rb_r;
  assign toggle_c  = hit_r != flag_rd_c[rb_r];
  assign q_last_c  = ((row_r >> j_r) >> 1) == '0;
  assign out_free  = !out_valid_r || !out_stall;
  assign emit_c    = out_free &&
                     ((state_r == S_EMIT) || (state_r == S_Q_SCAN && row_r[j_r]));

  always_comb begin
    hit_c = 1'b1;
    for (int a = 0; a < 3; a++) begin
      if (!((pbuf_r[a*2+1] > pbuf_r[6+a*2]) && (pbuf_r[a*2] < pbuf_r[7+a*2]))) begin
        hit_c = 1'b0;
      end
    end
  end

  always_comb begin
    ep_we      = 1'b0;
    ep_waddr   = '0;
    ep_wdata   = '0;
    ep_raddr   = '0;
    pos_we     = 1'b0;
    pos_waddr  = '0;
    pos_wdata  = '0;
    pos_raddr  = '0;
    flag_we    = 1'b0;
    flag_waddr = '0;
    flag_wdata = '0;
    flag_raddr = '0;
    case (state_r)
      S_DISP: begin
        flag_raddr = req_r.object;
      end
      S_ADD_EP: begin
        ep_we     = 1'b1;
        ep_waddr  = ep_addr(ax_r, add_pos_c);
        ep_wdata  = {newval_c, own_add_c};
        pos_we    = 1'b1;
        pos_waddr = pos_addr(count_r[OBJ_W-1:0], ax_r, m_r);
        pos_wdata = add_pos_c;
      end
      S_UPD_RDPOS: begin
        pos_raddr = pos_addr(req_r.object, ax_r, m_r);
      end
      S_UPD_POS: begin
        if (!upd_bad_c) begin
          ep_raddr = ep_addr(ax_r, pos_rd_c);
        end
      end
      S_UPD_OLD: begin
        ep_we    = 1'b1;
        ep_waddr = ep_addr(ax_r, pos_r);
        ep_wdata = {newval_c, ep_own_c};
      end
      S_STEP: begin
        if (bound_c) begin
          ep_raddr = ep_addr(ax_r, nb_c);
        end
      end
      S_CMP: begin
        if (swap_c) begin
          ep_we     = 1'b1;
          ep_waddr  = ep_addr(ax_r, nb_c);
          ep_wdata  = {mv_val_r, mv_own_r};
          pos_we    = 1'b1;
          pos_waddr = pos_addr(mv_own_r[OBJ_W-1:0], ax_r, mv_own_r[OBJ_W]);
          pos_wdata = nb_c;
        end
      end
      S_SW2: begin
        ep_we     = 1'b1;
        ep_waddr  = ep_addr(ax_r, pos_r);
        ep_wdata  = {nb_val_r, nb_own_r};
        pos_we    = 1'b1;
        pos_waddr = pos_addr(nb_own_r[OBJ_W-1:0], ax_r, nb_own_r[OBJ_W]);
        pos_wdata = pos_r;
      end
      S_RT_RD: begin
        if (k_r < 4'(RT_N)) begin
          pos_raddr = pos_addr(rt_obj_c, sub_c[2:1], sub_c[0]);
        end
      end
      S_RT_EVAL: begin
        flag_raddr = ra_r;
      end
      S_RT_FA: begin
        if (toggle_c) begin
          flag_we    = 1'b1;
          flag_waddr = ra_r;
          flag_wdata = flag_rd_c ^ (MAX_OBJECTS'(1) << rb_r);
          flag_raddr = rb_r;
        end
      end
      S_RT_FB: begin
        flag_we    = 1'b1;
        flag_waddr = rb_r;
        flag_wdata = flag_rd_c ^ (MAX_OBJECTS'(1) << ra_r);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    pos_ra_r  <= pos_raddr;
    flag_ra_r <= flag_raddr;
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      pair_r       <= '0;
      out_valid_r  <= 1'b0;
      pos_valid_r  <= '0;
      flag_valid_r <= '0;
    end else begin
      if (pos_we) begin
        pos_valid_r[pos_waddr] <= 1'b1;
      end
      if (flag_we) begin
        flag_valid_r[flag_waddr] <= 1'b1;
      end
      if (emit_c) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            req_r   <= in_data;
            state_r <= S_DISP;
          end
        end
        S_DISP: begin
          em_slot_r  <= '0;
          em_valid_r <= 1'b0;
          em_err_r   <= ERR_NONE;
          ax_r       <= '0;
          m_r        <= 1'b0;
          case (cmd_t'(req_r.command))
            CMD_ADD: begin
              if (count_r == CNT_W'(MAX_OBJECTS)) begin
                em_err_r <= ERR_FULL;
                state_r  <= S_EMIT;
              end else begin
                state_r <= S_ADD_EP;
              end
            end
            CMD_UPDATE: begin
              if ({1'b0, req_r.object} >= count_r) begin
                em_err_r <= ERR_UNKNOWN;
                state_r  <= S_EMIT;
              end else begin
                state_r <= S_UPD_RDPOS;
              end
            end
            CMD_QUERY: begin
              if ({1'b0, req_r.object} >= count_r) begin
                em_err_r <= ERR_UNKNOWN;
                state_r  <= S_EMIT;
              end else begin
                state_r <= S_Q_WAIT;
              end
            end
            default: begin
              state_r <= S_EMIT;
            end
          endcase
        end
        S_ADD_EP: begin
          pos_r    <= add_pos_c;
          top_r    <= add_pos_c;
          mv_val_r <= newval_c;
          mv_own_r <= own_add_c;
          dn_r     <= newval_c < COORD_TOP;
          state_r  <= S_STEP;
        end
        S_UPD_RDPOS: begin
          state_r <= S_UPD_POS;
        end
        S_UPD_POS: begin
          pos_r   <= pos_rd_c;
          top_r   <= top_upd_c;
          state_r <= upd_bad_c ? S_NEXT_EP : S_UPD_OLD;
        end
        S_UPD_OLD: begin
          mv_val_r <= newval_c;
          mv_own_r <= ep_own_c;
          dn_r     <= newval_c < ep_val_c;
          state_r  <= S_STEP;
        end
        S_STEP: begin
          state_r <= bound_c ? S_CMP : S_NEXT_EP;
        end
        S_CMP: begin
          if (swap_c) begin
            nb_val_r <= ep_val_c;
            nb_own_r <= ep_own_c;
            state_r  <= S_SW2;
          end else begin
            state_r <= S_NEXT_EP;
          end
        end
        S_SW2: begin
          pos_r   <= nb_c;
          ra_r    <= nb_own_r[OBJ_W-1:0];
          rb_r    <= mv_own_r[OBJ_W-1:0];
          k_r     <= '0;
          state_r <= (nb_own_r[OBJ_W-1:0] == mv_own_r[OBJ_W-1:0]) ? S_STEP : S_RT_RD;
        end
        S_RT_RD: begin
          if (k_r != '0) begin
            pbuf_r[k_r - 4'd1] <= pos_rd_c;
          end
          if (k_r == 4'(RT_N)) begin
            state_r <= S_RT_EVAL;
          end else begin
            k_r <= k_r + 4'd1;
          end
        end
        S_RT_EVAL: begin
          hit_r   <= hit_c;
          state_r <= S_RT_FA;
        end
        S_RT_FA: begin
          if (toggle_c) begin
            pair_r  <= hit_r ? pair_r + PAIR_W'(1) : pair_r - PAIR_W'(1);
            state_r <= S_RT_FB;
          end else begin
            state_r <= S_STEP;
          end
        end
        S_RT_FB: begin
          state_r <= S_STEP;
        end
        S_NEXT_EP: begin
          if (!m_r) begin
            m_r     <= 1'b1;
            state_r <= (cmd_t'(req_r.command) == CMD_ADD) ? S_ADD_EP : S_UPD_RDPOS;
          end else begin
            m_r <= 1'b0;
            if (ax_r == 2'd2) begin
              if (cmd_t'(req_r.command) == CMD_ADD) begin
                em_slot_r  <= count_r[OBJ_W-1:0];
                em_valid_r <= 1'b1;
                count_r    <= count_r + CNT_W'(1);
              end
              state_r <= S_EMIT;
            end else begin
              ax_r    <= ax_r + 2'd1;
              state_r <= (cmd_t'(req_r.command) == CMD_ADD) ? S_ADD_EP : S_UPD_RDPOS;
            end
          end
        end
        S_Q_WAIT: begin
          row_r   <= flag_rd_c;
          j_r     <= '0;
          state_r <= (flag_rd_c == '0) ? S_EMIT : S_Q_SCAN;
        end
        S_Q_SCAN: begin
          if (row_r[j_r]) begin
            if (out_free) begin
              out_data_r.slot       <= j_r;
              out_data_r.slot_valid <= 1'b1;
              out_data_r.pair_count <= pair_r;
              out_data_r.error      <= ERR_NONE;
              out_data_r.last       <= q_last_c;
              j_r                   <= j_r + OBJ_W'(1);
              if (q_last_c) begin
                state_r <= S_IDLE;
              end
            end
          end else begin
            j_r <= j_r + OBJ_W'(1);
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_data_r.slot       <= em_slot_r;
            out_data_r.slot_valid <= em_valid_r;
            out_data_r.pair_count <= pair_r;
            out_data_r.error      <= em_err_r;
            out_data_r.last       <= 1'b1;
            state_r               <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `SAP_CHECK_ALWAYS(a_count_range, count_r <= CNT_W'(MAX_OBJECTS), "object count overflow")
  `SAP_CHECK_ALWAYS(a_pair_range, pair_r <= PAIR_W'(PAIR_MAX), "pair count out of range")
  `SAP_CHECK_IMP(a_out_src, $rose(out_valid_r), $past(state_r == S_EMIT || state_r == S_Q_SCAN), "result beat from wrong state")
  `SAP_CHECK_IMP(a_flag_pair, state_r == S_RT_FB, $past(toggle_c) && ra_r != rb_r, "flag row b written without toggle")

endmodule

[tb/sweep_and_prune_broadphase_checker.sv]
`timescale 1ns / 1ps

module sweep_and_prune_broadphase_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  sap_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  sap_pkg::out_item_t out_data,
  output int                 fail_count,
  output int                 pending
);
  import sap_pkg::*;

  int         ep_val[3][SLOTS];
  logic [5:0] ep_own[3][SLOTS];
  int         ep_pos[MAX_OBJECTS][3][2];
  logic [31:0] overlap_rows[MAX_OBJECTS];
  int         box_count;
  int         pair_count;
  out_item_t  result_q[$];

  assign pending = result_q.size();

  task automatic report(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  function automatic void retest_pair(input int a, input int b);
    logic hit;
    logic was;
    a = a & 31;
    b = b & 31;
    if (a == b) return;
    hit = 1'b1;
    for (int ax = 0; ax < 3; ax++)
      if (!(ep_pos[a][ax][1] > ep_pos[b][ax][0] && ep_pos[a][ax][0] < ep_pos[b][ax][1]))
        hit = 1'b0;
    was = overlap_rows[a][b];
    if (hit && !was) begin
      overlap_rows[a][b] = 1'b1;
      overlap_rows[b][a] = 1'b1;
      pair_count++;
    end else if (!hit && was) begin
      overlap_rows[a][b] = 1'b0;
      overlap_rows[b][a] = 1'b0;
      pair_count--;
    end
  endfunction

  function automatic void track_position(input int ax, input int p);
    logic [5:0] own;
    own = ep_own[ax][p];
    ep_pos[own[4:0]][ax][own[5]] = p;
  endfunction

  function automatic void swap_entries(input int ax, input int a, input int b);
    int         v;
    logic [5:0] o;
    v = ep_val[ax][a];
    o = ep_own[ax][a];
    ep_val[ax][a] = ep_val[ax][b];
    ep_own[ax][a] = ep_own[ax][b];
    ep_val[ax][b] = v;
    ep_own[ax][b] = o;
    track_position(ax, a);
    track_position(ax, b);
  endfunction

  function automatic void sort_endpoint(input int ax, input int p, input int nv,
                                        input int top);
    int old;
    if (p < 1 || p > top || top >= SLOTS) return;
    old = ep_val[ax][p];
    ep_val[ax][p] = nv;
    if (nv < old) begin
      while (p > 1 && nv < ep_val[ax][p-1]) begin
        swap_entries(ax, p - 1, p);
        retest_pair(ep_own[ax][p], ep_own[ax][p-1]);
        p--;
      end
    end else begin
      while (p < top && nv > ep_val[ax][p+1]) begin
        swap_entries(ax, p + 1, p);
        retest_pair(ep_own[ax][p], ep_own[ax][p+1]);
        p++;
      end
    end
  endfunction

  function automatic void push_result(input int s, input logic v, input logic [1:0] e,
                                      input logic l);
    out_item_t r;
    r.slot = s[4:0];
    r.slot_valid = v;
    r.pair_count = pair_count[8:0];
    r.error = e;
    r.last = l;
    result_q.insert(result_q.size(), r);
  endfunction

  function automatic void predict_command(input in_item_t d);
    int lo[3];
    int hi[3];
    int obj;
    int base;
    int found;
    lo[0] = int'(d.min_x); lo[1] = int'(d.min_y); lo[2] = int'(d.min_z);
    hi[0] = int'(d.max_x); hi[1] = int'(d.max_y); hi[2] = int'(d.max_z);
    obj = d.object;
    case (cmd_t'(d.command))
      CMD_ADD: begin
        if (box_count >= MAX_OBJECTS) begin
          push_result(0, 1'b0, ERR_FULL, 1'b1);
        end else begin
          base = 2 * box_count;
          for (int ax = 0; ax < 3; ax++) begin
            ep_val[ax][base+1] = int'(COORD_TOP);
            ep_own[ax][base+1] = 6'(box_count);
            ep_pos[box_count][ax][0] = base + 1;
            sort_endpoint(ax, base + 1, lo[ax], base + 1);
            ep_val[ax][base+2] = int'(COORD_TOP);
            ep_own[ax][base+2] = 6'(box_count | 32);
            ep_pos[box_count][ax][1] = base + 2;
            sort_endpoint(ax, base + 2, hi[ax], base + 2);
          end
          push_result(box_count, 1'b1, ERR_NONE, 1'b1);
          box_count++;
        end
      end
      CMD_UPDATE: begin
        if (obj >= box_count) begin
          push_result(0, 1'b0, ERR_UNKNOWN, 1'b1);
        end else begin
          for (int ax = 0; ax < 3; ax++) begin
            sort_endpoint(ax, ep_pos[obj][ax][0], lo[ax], 2 * box_count);
            sort_endpoint(ax, ep_pos[obj][ax][1], hi[ax], 2 * box_count);
          end
          push_result(0, 1'b0, ERR_NONE, 1'b1);
        end
      end
      CMD_QUERY: begin
        if (obj >= box_count) begin
          push_result(0, 1'b0, ERR_UNKNOWN, 1'b1);
        end else begin
          found = 0;
          for (int j = 0; j < MAX_OBJECTS; j++)
            if (overlap_rows[obj][j]) begin
              push_result(j, 1'b1, ERR_NONE, 1'b0);
              found++;
            end
          if (found == 0) push_result(0, 1'b0, ERR_NONE, 1'b1);
          else result_q[result_q.size()-1].last = 1'b1;
        end
      end
      default: push_result(0, 1'b0, ERR_NONE, 1'b1);
    endcase
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      for (int o = 0; o < MAX_OBJECTS; o++) begin
        overlap_rows[o] = '0;
        for (int ax = 0; ax < 3; ax++) begin
          ep_pos[o][ax][0] = 0;
          ep_pos[o][ax][1] = 0;
        end
      end
      box_count = 0;
      pair_count = 0;
      fail_count = 0;
      result_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          report("result beat with nothing expected");
        end else begin
          want = result_q.pop_front();
          if (out_data.slot !== want.slot)
            report($sformatf("slot %0d, want %0d", out_data.slot, want.slot));
          if (out_data.slot_valid !== want.slot_valid)
            report($sformatf("slot_valid %0b, want %0b", out_data.slot_valid,
                             want.slot_valid));
          if (out_data.pair_count !== want.pair_count)
            report($sformatf("pair_count %0d, want %0d", out_data.pair_count,
                             want.pair_count));
          if (out_data.error !== want.error)
            report($sformatf("error %0d, want %0d", out_data.error, want.error));
          if (out_data.last !== want.last)
            report($sformatf("last %0b, want %0b", out_data.last, want.last));
        end
      end
      if (in_valid && !in_stall) predict_command(in_data);
    end
  end

endmodule

[tb/sweep_and_prune_broadphase_tb.sv]
`timescale 1ns / 1ps

module sweep_and_prune_broadphase_tb;
  import sap_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  int        fail_count;
  int        pending;
  logic      idling_on;
  int        stall_left;
  int        cycle_count;
  int        adds_sent;

  sweep_and_prune_broadphase uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  sweep_and_prune_broadphase_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 20000000) begin
      $display("sweep_and_prune_broadphase_tb: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left == 0) begin
      out_stall <= idling_on && ($urandom_range(0, 2) == 0);
      stall_left <= $urandom_range(1, 16);
    end else begin
      stall_left <= stall_left - 1;
    end
  end

  function automatic in_item_t make_command(input cmd_t c, input int obj,
                                            input int x0, input int y0, input int z0,
                                            input int x1, input int y1, input int z1);
    in_item_t it;
    it.command = c;
    it.object = obj[4:0];
    it.min_x = x0[15:0]; it.min_y = y0[15:0]; it.min_z = z0[15:0];
    it.max_x = x1[15:0]; it.max_y = y1[15:0]; it.max_z = z1[15:0];
    return it;
  endfunction

  function automatic in_item_t random_box(input cmd_t c, input int obj);
    int lo[3];
    int hi[3];
    for (int ax = 0; ax < 3; ax++) begin
      if ($urandom_range(0, 4) == 0) begin
        lo[ax] = $urandom_range(0, 65535);
        hi[ax] = $urandom_range(0, 65535);
      end else begin
        lo[ax] = $urandom_range(0, 2000) - 1000;
        hi[ax] = lo[ax] + $urandom_range(0, 400);
        if ($urandom_range(0, 15) == 0) hi[ax] = lo[ax] - $urandom_range(1, 50);
        if ($urandom_range(0, 7) == 0) hi[ax] = lo[ax];
      end
    end
    return make_command(c, obj, lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
  endfunction

  task automatic send(input in_item_t it);
    in_valid <= 1'b1;
    in_data <= it;
    forever begin
      @(negedge clk);
      if (!in_stall) break;
    end
    @(posedge clk);
    if (it.command == CMD_ADD) adds_sent++;
    if (idling_on && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  initial begin
    in_item_t it;
    int r;
    int obj;
    int guard;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    idling_on = 1'b1;
    adds_sent = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(make_command(CMD_QUERY, 0, 0, 0, 0, 0, 0, 0));
    send(make_command(CMD_UPDATE, 31, 0, 0, 0, 0, 0, 0));
    send(make_command(CMD_NOP, 17, -1, -1, -1, -1, -1, -1));
    send(make_command(CMD_ADD, 31, -32768, -32768, -32768, 32767, 32767, 32767));
    send(make_command(CMD_QUERY, 0, 0, 0, 0, 0, 0, 0));
    send(make_command(CMD_ADD, 0, 10, 10, 10, 20, 20, 20));
    send(make_command(CMD_ADD, 0, 20, 20, 20, 30, 30, 30));
    send(make_command(CMD_ADD, 0, 15, 15, 15, 15, 15, 15));
    send(make_command(CMD_ADD, 0, 500, 500, 500, -500, -500, -500));
    send(make_command(CMD_ADD, 0, 32767, 32767, 32767, -32768, -32768, -32768));
    send(make_command(CMD_QUERY, 0, 0, 0, 0, 0, 0, 0));
    send(make_command(CMD_QUERY, 1, 0, 0, 0, 0, 0, 0));
    send(make_command(CMD_QUERY, 4, 0, 0, 0, 0, 0, 0));
    send(make_command(CMD_UPDATE, 1, 5, 5, 5, 25, 25, 25));
    send(make_command(CMD_QUERY, 1, 0, 0, 0, 0, 0, 0));
    send(make_command(CMD_UPDATE, 0, 100, 100, 100, 90, 90, 90));
    send(make_command(CMD_QUERY, 2, 0, 0, 0, 0, 0, 0));
    send(make_command(CMD_UPDATE, 2, -32768, -32768, -32768, 32767, 32767, 32767));
    send(make_command(CMD_QUERY, 2, 0, 0, 0, 0, 0, 0));
    send(make_command(CMD_UPDATE, 9, 0, 0, 0, 0, 0, 0));

    for (int i = 0; i < 250; i++) begin
      if (i == 210) idling_on = 1'b0;
      r = $urandom_range(0, 99);
      obj = (adds_sent > 0) ? $urandom_range(0, (adds_sent > 32 ? 32 : adds_sent) - 1) : 0;
      if ($urandom_range(0, 9) == 0) obj = $urandom_range(0, 31);
      if ((adds_sent < 32 && r < 45) || r >= 97) it = random_box(CMD_ADD, $urandom_range(0, 31));
      else if (r < 70) it = random_box(CMD_UPDATE, obj);
      else if (r < 93) it = random_box(CMD_QUERY, obj);
      else it = random_box(CMD_NOP, obj);
      send(it);
    end
    in_valid <= 1'b0;

    guard = 0;
    while (pending != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("sweep_and_prune_broadphase_tb: PASS");
    end else begin
      $display("sweep_and_prune_broadphase_tb: FAIL");
    end
    $finish;
  end

endmodule
